// ===== rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the windowed SSIM meter.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // Sample and field widths.
   localparam int SAMPLE_W = 8;
   localparam int SUM_W    = 16;
   localparam int SQ_W     = 24;
   localparam int SSIM_W   = 18;
   localparam int COUNT_W  = 25;
   localparam int TOTAL_W  = 48;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int EDGE_REG_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_EDGE  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;
   localparam logic [EDGE_REG_W-1:0] WINDOW_EDGE_RESET  = 5'd8;

   // Stabilizing constants c1 and c2, scaled by 256.
   localparam int C1_SCALED = 1665;
   localparam int C2_SCALED = 14982;
   localparam int P_SHIFT   = 9;
   localparam int Q_SHIFT   = 8;
   localparam int Q_FRAC    = 16;

   // Width of the four SSIM factors, signed; covers window edges up to 32.
   localparam int PQ_W   = 46;
   localparam int PROD_W = 2 * (PQ_W - 1);
   localparam int REM_W  = PROD_W + Q_FRAC;

   localparam logic [Q_FRAC:0] ONE_Q16 = 17'h10000;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic signed [TOTAL_W:0] TOTAL_LIMIT = {2'b00, {(TOTAL_W-1){1'b1}}};

   // The five running sums kept for one window column.
   typedef struct packed {
      logic [SUM_W-1:0] ref_sum;
      logic [SUM_W-1:0] cmp_sum;
      logic [SQ_W-1:0]  ref_square;
      logic [SQ_W-1:0]  cmp_square;
      logic [SQ_W-1:0]  cross_sum;
   } column_sums_type;

   // Status returned by the window SSIM unit.
   typedef struct packed {
      logic                     done;
      logic signed [SSIM_W-1:0] ssim;
   } win_result_type;

endpackage

// ===== rtl/ssm_div.sv =====
// ----------------------------------------------------------------------------
// ssm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssm_div #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/ssm_window.sv =====
// ----------------------------------------------------------------------------
// ssm_window
// SSIM of one finished window from its five sums, in Q.16.
// ----------------------------------------------------------------------------
module ssm_window #(
   parameter int EDGE_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [EDGE_W-1:0]       edge_len,
   input  ssm_pkg::column_sums_type sums,
   output ssm_pkg::win_result_type result
);

   localparam int PQ_W   = ssm_pkg::PQ_W;
   localparam int PROD_W = ssm_pkg::PROD_W;
   localparam int REM_W  = ssm_pkg::REM_W;
   localparam int SUM_W  = ssm_pkg::SUM_W;
   localparam int SQ_W   = ssm_pkg::SQ_W;
   localparam int Q_FRAC = ssm_pkg::Q_FRAC;
   localparam int CNT_W  = $clog2(PQ_W);

   typedef enum logic [3:0] {
      W_IDLE, W_PROD, W_SCALE, W_TERM, W_PQ, W_CHECK, W_MUL, W_DIV_SETUP,
      W_DIV, W_FINISH
   } wstate_type;

   wstate_type                state_ff;
   ssm_pkg::column_sums_type  sums_ff;
   logic [EDGE_W-1:0]         e_ff;
   logic [2*EDGE_W-1:0]       n_ff;
   logic [2*SUM_W-1:0]        ab_ff;
   logic [2*SUM_W-1:0]        a2_ff;
   logic [2*SUM_W-1:0]        b2_ff;
   logic [SQ_W:0]             ssum_ff;
   logic [4*EDGE_W-1:0]       nn_ff;
   logic [2*EDGE_W+SQ_W-1:0]  nsab_ff;
   logic [2*EDGE_W+SQ_W:0]    nss_ff;
   logic [2*SUM_W:0]          sq_ff;
   logic signed [PQ_W-1:0]    k1_ff, k2_ff, d1_ff, d2_ff;
   logic signed [PQ_W-1:0]    p1_ff, p2_ff, q1_ff, q2_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         mcand1_ff, mcand2_ff, acc1_ff, acc2_ff;
   logic [PQ_W-2:0]           mplier1_ff, mplier2_ff;
   logic [REM_W-1:0]          rem_ff, dvs_ff;
   logic [Q_FRAC:0]           q_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      done_ff;
   logic signed [ssm_pkg::SSIM_W-1:0] ssim_ff;

   logic signed [PQ_W-1:0] p2_abs;

   assign p2_abs = p2_ff[PQ_W-1] ? -p2_ff : p2_ff;

   // Sequencer: products, scaling, factors, check, serial multiply, serial divide.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            W_IDLE: begin
               if (start) begin
                  sums_ff  <= sums;
                  e_ff     <= edge_len;
                  state_ff <= W_PROD;
               end
            end
            W_PROD: begin
               n_ff    <= (2*EDGE_W)'(e_ff) * (2*EDGE_W)'(e_ff);
               ab_ff   <= (2*SUM_W)'(sums_ff.ref_sum) * (2*SUM_W)'(sums_ff.cmp_sum);
               a2_ff   <= (2*SUM_W)'(sums_ff.ref_sum) * (2*SUM_W)'(sums_ff.ref_sum);
               b2_ff   <= (2*SUM_W)'(sums_ff.cmp_sum) * (2*SUM_W)'(sums_ff.cmp_sum);
               ssum_ff <= (SQ_W+1)'(sums_ff.ref_square) + (SQ_W+1)'(sums_ff.cmp_square);
               state_ff <= W_SCALE;
            end
            W_SCALE: begin
               nn_ff   <= (4*EDGE_W)'(n_ff) * (4*EDGE_W)'(n_ff);
               nsab_ff <= (2*EDGE_W+SQ_W)'(n_ff) * (2*EDGE_W+SQ_W)'(sums_ff.cross_sum);
               nss_ff  <= (2*EDGE_W+SQ_W+1)'(n_ff) * (2*EDGE_W+SQ_W+1)'(ssum_ff);
               sq_ff   <= (2*SUM_W+1)'(a2_ff) + (2*SUM_W+1)'(b2_ff);
               state_ff <= W_TERM;
            end
            W_TERM: begin
               k1_ff <= signed'(PQ_W'(nn_ff) * PQ_W'(ssm_pkg::C1_SCALED));
               k2_ff <= signed'(PQ_W'(nn_ff) * PQ_W'(ssm_pkg::C2_SCALED));
               d1_ff <= signed'(PQ_W'(nsab_ff)) - signed'(PQ_W'(ab_ff));
               d2_ff <= signed'(PQ_W'(nss_ff)) - signed'(PQ_W'(sq_ff));
               state_ff <= W_PQ;
            end
            W_PQ: begin
               p1_ff <= signed'(PQ_W'(ab_ff) << ssm_pkg::P_SHIFT) + k1_ff;
               p2_ff <= (d1_ff <<< ssm_pkg::P_SHIFT) + k2_ff;
               q1_ff <= signed'(PQ_W'(sq_ff) << ssm_pkg::Q_SHIFT) + k1_ff;
               q2_ff <= (d2_ff <<< ssm_pkg::Q_SHIFT) + k2_ff;
               state_ff <= W_CHECK;
            end
            W_CHECK: begin
               // A non-positive denominator factor or p1 makes the window zero.
               if (q2_ff <= 0 || q1_ff <= 0 || p1_ff <= 0) begin
                  ssim_ff  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= W_IDLE;
               end else begin
                  neg_ff     <= p2_ff[PQ_W-1];
                  mcand1_ff  <= PROD_W'(p1_ff[PQ_W-2:0]);
                  mplier1_ff <= p2_abs[PQ_W-2:0];
                  mcand2_ff  <= PROD_W'(q1_ff[PQ_W-2:0]);
                  mplier2_ff <= q2_ff[PQ_W-2:0];
                  acc1_ff    <= '0;
                  acc2_ff    <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= W_MUL;
               end
            end
            W_MUL: begin
               // Shift-add multiply of numerator and denominator products.
               acc1_ff    <= acc1_ff + (mplier1_ff[0] ? mcand1_ff : '0);
               acc2_ff    <= acc2_ff + (mplier2_ff[0] ? mcand2_ff : '0);
               mcand1_ff  <= mcand1_ff << 1;
               mcand2_ff  <= mcand2_ff << 1;
               mplier1_ff <= mplier1_ff >> 1;
               mplier2_ff <= mplier2_ff >> 1;
               cnt_ff     <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(PQ_W - 2)) begin
                  state_ff <= W_DIV_SETUP;
               end
            end
            W_DIV_SETUP: begin
               rem_ff <= {acc1_ff, {Q_FRAC{1'b0}}};
               dvs_ff <= REM_W'(acc2_ff) << (Q_FRAC - 1);
               cnt_ff <= '0;
               if (acc1_ff >= acc2_ff) begin
                  // Ratio of one or more saturates to 1.0.
                  q_ff     <= ssm_pkg::ONE_Q16;
                  state_ff <= W_FINISH;
               end else begin
                  q_ff     <= '0;
                  state_ff <= W_DIV;
               end
            end
            W_DIV: begin
               if (rem_ff >= dvs_ff) begin
                  rem_ff <= rem_ff - dvs_ff;
                  q_ff   <= {q_ff[Q_FRAC-1:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[Q_FRAC-1:0], 1'b0};
               end
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(Q_FRAC - 1)) begin
                  state_ff <= W_FINISH;
               end
            end
            W_FINISH: begin
               ssim_ff  <= neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});
               done_ff  <= 1'b1;
               state_ff <= W_IDLE;
            end
            default: begin
               state_ff <= W_IDLE;
            end
         endcase
      end
   end

   assign result.done = done_ff;
   assign result.ssim = ssim_ff;

endmodule

// ===== rtl/windowed_ssim_meter_top.sv =====
// ----------------------------------------------------------------------------
// windowed_ssim_meter_top
// Mean SSIM of one plane over non-overlapping square windows.
// ----------------------------------------------------------------------------
// Sample pairs arrive in raster order. For each request the column sums are
// read from the sum memory and written back updated the next cycle, and no
// new request is taken before the write-back. A request that completes a
// window also waits for the window unit, whose serial multiplier takes 45
// steps and serial divider 16 steps. The frame's last request also waits for
// the mean divide (47 steps). A frame result that waits behind an earlier
// result not yet taken holds the block, and no request is taken until the
// earlier result leaves. After reset all MAX_LINE entries of the sum memory
// are cleared, and after reset or any register write the window position is
// recomputed by the position divider; no request is taken meanwhile.
module windowed_ssim_meter_top #(
   parameter int MAX_LINE   = 4096,
   parameter int MAX_WINDOW = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ssm_pkg::SAMPLE_W-1:0]           req_ref_sample,
   input  logic [ssm_pkg::SAMPLE_W-1:0]           req_cmp_sample,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ssm_pkg::SSIM_W-1:0]      rsp_ssim_mean,
   output logic [ssm_pkg::COUNT_W-1:0]            rsp_window_count,

   input  logic                                   csr_we,
   input  logic [ssm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ssm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int IW  = $clog2(MAX_LINE);
   localparam int DW  = $clog2(MAX_LINE + 1);
   localparam int EW  = $clog2(MAX_WINDOW + 1);
   localparam int LW  = (DW > ssm_pkg::CSR_DATA_W) ? DW : ssm_pkg::CSR_DATA_W;
   localparam int EXW = (EW > ssm_pkg::EDGE_REG_W) ? EW : ssm_pkg::EDGE_REG_W;
   localparam int TW  = ssm_pkg::TOTAL_W;
   localparam int MW  = ssm_pkg::TOTAL_W - 1;
   localparam int SW  = ssm_pkg::SAMPLE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_RC_START, ST_RC_WAIT, ST_IDLE, ST_UPD, ST_WIN,
      ST_MEAN_START, ST_MEAN_WAIT, ST_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [ssm_pkg::CSR_DATA_W-1:0] width_raw_ff;
   logic [ssm_pkg::CSR_DATA_W-1:0] height_raw_ff;
   logic [ssm_pkg::EDGE_REG_W-1:0] edge_raw_ff;
   logic                           dirty_ff;

   // Position and window bookkeeping.
   logic [IW-1:0] x_ff, y_ff, col_ff, clr_idx_ff;
   logic [EW-1:0] xr_ff, yr_ff, wr_ff, hr_ff;
   logic [1:0]    job_ff;
   logic          last_ff;
   logic [SW-1:0] a_ff, b_ff;

   // Frame accumulation and result.
   logic signed [TW-1:0]              total_ff;
   logic [ssm_pkg::COUNT_W-1:0]       count_ff;
   logic                              mean_neg_ff;
   logic                              rsp_valid_ff;
   logic signed [ssm_pkg::SSIM_W-1:0] mean_ff;
   logic signed [ssm_pkg::SSIM_W-1:0] rsp_mean_ff;
   logic [ssm_pkg::COUNT_W-1:0]       rsp_count_ff;

   // Column sum memory.
   ssm_pkg::column_sums_type sum_mem [MAX_LINE];
   ssm_pkg::column_sums_type rd_data_ff;
   ssm_pkg::column_sums_type base_sums, new_sums, mem_wdata;
   logic                     mem_we;
   logic [IW-1:0]            mem_waddr;

   logic [LW-1:0]  w_ext, h_ext, w_cl, h_cl;
   logic [EXW-1:0] e_ext, e_cl;
   logic [DW-1:0]  w_val, h_val, wlim, hlim;
   logic [EW-1:0]  e_val;
   logic           req_accept, in_win, first_px, win_end, line_end, last_line;
   logic           xr_wrap, yr_wrap, win_start, out_load;
   logic [2*SW-1:0] aa, bb, ab;

   logic              pdiv_start, pdiv_done;
   logic [DW-1:0]     pdiv_numer, pdiv_quo;
   logic [EW-1:0]     pdiv_rem;
   logic              mdiv_start, mdiv_done;
   logic [MW-1:0]     mdiv_quo;
   logic [ssm_pkg::COUNT_W-1:0] mdiv_rem;
   logic signed [TW-1:0] total_abs;

   ssm_pkg::win_result_type  win_res;
   logic signed [TW:0]       total_sum;

   // Registers as used: clamped to their meaningful range.
   assign w_ext = LW'(width_raw_ff);
   assign h_ext = LW'(height_raw_ff);
   assign e_ext = EXW'(edge_raw_ff);
   assign w_cl  = (w_ext == '0) ? LW'(1) : (w_ext > LW'(MAX_LINE)) ? LW'(MAX_LINE) : w_ext;
   assign h_cl  = (h_ext == '0) ? LW'(1) : (h_ext > LW'(MAX_LINE)) ? LW'(MAX_LINE) : h_ext;
   assign e_cl  = (e_ext == '0) ? EXW'(1) :
                  (e_ext > EXW'(MAX_WINDOW)) ? EXW'(MAX_WINDOW) : e_ext;
   assign w_val = w_cl[DW-1:0];
   assign h_val = h_cl[DW-1:0];
   assign e_val = e_cl[EW-1:0];

   // Extent covered by whole windows.
   assign wlim = w_val - DW'(wr_ff);
   assign hlim = h_val - DW'(hr_ff);

   assign req_stall  = (state_ff != ST_IDLE) || dirty_ff || csr_we;
   assign req_accept = req_valid && !req_stall;

   assign in_win    = (DW'(x_ff) < wlim) && (DW'(y_ff) < hlim);
   assign first_px  = (xr_ff == '0) && (yr_ff == '0);
   assign win_end   = (xr_ff == e_val - EW'(1)) && (yr_ff == e_val - EW'(1));
   assign line_end  = (DW'(x_ff) + DW'(1)) >= w_val;
   assign last_line = (DW'(y_ff) + DW'(1)) >= h_val;
   assign xr_wrap   = (xr_ff + EW'(1)) == e_val;
   assign yr_wrap   = (yr_ff + EW'(1)) == e_val;
   assign win_start = (state_ff == ST_UPD) && in_win && win_end;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Sum update for the current sample pair.
   assign aa = (2*SW)'(a_ff) * (2*SW)'(a_ff);
   assign bb = (2*SW)'(b_ff) * (2*SW)'(b_ff);
   assign ab = (2*SW)'(a_ff) * (2*SW)'(b_ff);
   assign base_sums = first_px ? '0 : rd_data_ff;
   always_comb begin
      new_sums.ref_sum    = base_sums.ref_sum + ssm_pkg::SUM_W'(a_ff);
      new_sums.cmp_sum    = base_sums.cmp_sum + ssm_pkg::SUM_W'(b_ff);
      new_sums.ref_square = base_sums.ref_square + ssm_pkg::SQ_W'(aa);
      new_sums.cmp_square = base_sums.cmp_square + ssm_pkg::SQ_W'(bb);
      new_sums.cross_sum  = base_sums.cross_sum + ssm_pkg::SQ_W'(ab);
   end

   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_UPD) && in_win);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_idx_ff : col_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : new_sums;

   // Sum memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_data_ff <= sum_mem[col_ff];
      end
   end

   // Position recompute: x / e, x % e, y % e, width % e, height % e.
   always_comb begin
      case (job_ff)
         2'd0:    pdiv_numer = DW'(x_ff);
         2'd1:    pdiv_numer = DW'(y_ff);
         2'd2:    pdiv_numer = w_val;
         default: pdiv_numer = h_val;
      endcase
   end
   assign pdiv_start = (state_ff == ST_RC_START);

   ssm_div #(.NUM_W(DW), .DEN_W(EW)) u_pos_div (
      .clock     (clock),
      .reset     (reset),
      .start     (pdiv_start),
      .numer     (pdiv_numer),
      .denom     (e_val),
      .done      (pdiv_done),
      .quotient  (pdiv_quo),
      .remainder (pdiv_rem)
   );

   // Frame mean divide on magnitudes.
   assign total_abs  = total_ff[TW-1] ? -total_ff : total_ff;
   assign mdiv_start = (state_ff == ST_MEAN_START) && (count_ff != '0);

   ssm_div #(.NUM_W(MW), .DEN_W(ssm_pkg::COUNT_W)) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mdiv_start),
      .numer     (total_abs[MW-1:0]),
      .denom     (count_ff),
      .done      (mdiv_done),
      .quotient  (mdiv_quo),
      .remainder (mdiv_rem)
   );

   ssm_window #(.EDGE_W(EW)) u_window (
      .clock    (clock),
      .reset    (reset),
      .start    (win_start),
      .edge_len (e_val),
      .sums     (new_sums),
      .result   (win_res)
   );

   assign total_sum = (TW+1)'(total_ff) + (TW+1)'(win_res.ssim);

   // Main sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         width_raw_ff  <= ssm_pkg::FRAME_WIDTH_RESET;
         height_raw_ff <= ssm_pkg::FRAME_HEIGHT_RESET;
         edge_raw_ff   <= ssm_pkg::WINDOW_EDGE_RESET;
         dirty_ff      <= 1'b1;
         clr_idx_ff    <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         col_ff        <= '0;
         xr_ff         <= '0;
         yr_ff         <= '0;
         wr_ff         <= '0;
         hr_ff         <= '0;
         job_ff        <= '0;
         last_ff       <= 1'b0;
         total_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + IW'(1);
               if (clr_idx_ff == IW'(MAX_LINE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RC_START: begin
               if ((job_ff == 2'd0) && !csr_we) begin
                  dirty_ff <= 1'b0;
               end
               state_ff <= ST_RC_WAIT;
            end
            ST_RC_WAIT: begin
               if (pdiv_done) begin
                  case (job_ff)
                     2'd0: begin
                        col_ff <= pdiv_quo[IW-1:0];
                        xr_ff  <= pdiv_rem;
                     end
                     2'd1:    yr_ff <= pdiv_rem;
                     2'd2:    wr_ff <= pdiv_rem;
                     default: hr_ff <= pdiv_rem;
                  endcase
                  job_ff   <= job_ff + 2'd1;
                  state_ff <= (job_ff == 2'd3) ? ST_IDLE : ST_RC_START;
               end
            end
            ST_IDLE: begin
               if (dirty_ff) begin
                  job_ff   <= '0;
                  state_ff <= ST_RC_START;
               end else if (req_accept) begin
                  a_ff     <= req_ref_sample;
                  b_ff     <= req_cmp_sample;
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               // Advance the raster position.
               if (line_end) begin
                  x_ff   <= '0;
                  xr_ff  <= '0;
                  col_ff <= '0;
                  if (last_line) begin
                     y_ff  <= '0;
                     yr_ff <= '0;
                  end else begin
                     y_ff  <= y_ff + IW'(1);
                     yr_ff <= yr_wrap ? '0 : yr_ff + EW'(1);
                  end
               end else begin
                  x_ff <= x_ff + IW'(1);
                  if (xr_wrap) begin
                     xr_ff  <= '0;
                     col_ff <= col_ff + IW'(1);
                  end else begin
                     xr_ff <= xr_ff + EW'(1);
                  end
               end
               last_ff <= line_end && last_line;
               if (win_start) begin
                  state_ff <= ST_WIN;
               end else if (line_end && last_line) begin
                  state_ff <= ST_MEAN_START;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WIN: begin
               if (win_res.done) begin
                  // Saturating accumulation of window results.
                  if (total_sum > ssm_pkg::TOTAL_LIMIT) begin
                     total_ff <= TW'(ssm_pkg::TOTAL_LIMIT);
                  end else if (total_sum < -ssm_pkg::TOTAL_LIMIT) begin
                     total_ff <= TW'(-ssm_pkg::TOTAL_LIMIT);
                  end else begin
                     total_ff <= total_sum[TW-1:0];
                  end
                  if (count_ff != ssm_pkg::COUNT_MAX) begin
                     count_ff <= count_ff + ssm_pkg::COUNT_W'(1);
                  end
                  state_ff <= last_ff ? ST_MEAN_START : ST_IDLE;
               end
            end
            ST_MEAN_START: begin
               mean_neg_ff <= total_ff[TW-1];
               if (count_ff == '0) begin
                  mean_ff  <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MEAN_WAIT;
               end
            end
            ST_MEAN_WAIT: begin
               if (mdiv_done) begin
                  if (mdiv_quo > MW'(ssm_pkg::ONE_Q16)) begin
                     mean_ff <= mean_neg_ff ? -signed'({1'b0, ssm_pkg::ONE_Q16})
                                            : signed'({1'b0, ssm_pkg::ONE_Q16});
                  end else begin
                     mean_ff <= mean_neg_ff ? -signed'(ssm_pkg::SSIM_W'(mdiv_quo))
                                            : signed'(ssm_pkg::SSIM_W'(mdiv_quo));
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mean_ff  <= mean_ff;
                  rsp_count_ff <= count_ff;
                  total_ff     <= '0;
                  count_ff     <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // Register writes.
         if (csr_we) begin
            case (csr_index)
               ssm_pkg::REG_FRAME_WIDTH:  width_raw_ff  <= csr_wdata;
               ssm_pkg::REG_FRAME_HEIGHT: height_raw_ff <= csr_wdata;
               ssm_pkg::REG_WINDOW_EDGE:
                  edge_raw_ff <= csr_wdata[ssm_pkg::EDGE_REG_W-1:0];
               default: ;
            endcase
            dirty_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ssim_mean    = rsp_mean_ff;
   assign rsp_window_count = rsp_count_ff;

   // An accepted request always goes on to its sum update.
   a_accept_upd: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPD))
      else $error("accepted request did not reach the sum update");

   // Offsets inside a window stay below the window edge.
   a_offsets: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPD) && in_win) |-> ((xr_ff < e_val) && (yr_ff < e_val)))
      else $error("window offset out of range");

   // Loading a frame result restarts the frame totals.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && (count_ff == '0) && (total_ff == '0)))
      else $error("frame totals not restarted after result");

endmodule
